FILE: design/vbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and constants for the background subtractor.
// ----------------------------------------------------------------------------
package vbs_pkg;

  localparam int NUM_SAMPLES_DEF = 20;
  localparam int MAX_WIDTH_DEF   = 320;
  localparam int MAX_HEIGHT_DEF  = 240;

  localparam int CFG_W = 9;

  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd320;
  localparam logic [7:0] FRAME_HEIGHT_RST = 8'd240;
  localparam logic [7:0] MATCH_RADIUS_RST = 8'd20;
  localparam logic [4:0] MIN_MATCHES_RST  = 5'd1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MATCH_RADIUS = 2'd2,
    REG_MIN_MATCHES  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_INIT   = 1'b0,
    CMD_DETECT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_NBR,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DIR_UL = 3'd0,
    DIR_U  = 3'd1,
    DIR_UR = 3'd2,
    DIR_DL = 3'd3,
    DIR_D  = 3'd4,
    DIR_DR = 3'd5,
    DIR_L  = 3'd6,
    DIR_R  = 3'd7
  } dir_t;

endpackage

FILE: design/vbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/vibe_background_subtractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibe_background_subtractor
// ViBe background subtraction: per-pixel sample model in one wide memory.
// ----------------------------------------------------------------------------
// The sample store is one RAM word per pixel holding all NUM_SAMPLES samples
// side by side. Each request is handled alone. An init request steps through
// accept, write and result; a border detect through accept, border check and
// result; and an interior detect through accept, read, compare and
// own-sample write-back, and result. A neighbor read step is added
// when a neighbor sample is replaced; its write-back shares the result cycle.
// The single RAM port sets these steps. The result cycle repeats while the
// output register holds a stalled result. A result waits in the output
// register while the next request is already accepted.
module vibe_background_subtractor
  import vbs_pkg::*;
#(
  parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [7:0]       in_row,
  input  logic [8:0]       in_col,
  input  logic [7:0]       in_pixel_value,
  input  logic             in_self_update,
  input  logic [4:0]       in_self_slot,
  input  logic             in_neighbor_update,
  input  logic [2:0]       in_neighbor_dir,
  input  logic [4:0]       in_neighbor_slot,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_foreground,
  output logic             out_on_border
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 8 * NUM_SAMPLES;
  localparam int CW    = $clog2(NUM_SAMPLES + 1);
  localparam logic [8:0] MAXW9 = MAX_WIDTH > 511 ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [7:0] MAXH8 = MAX_HEIGHT > 255 ? 8'd255 : 8'(MAX_HEIGHT);
  localparam logic [AW-1:0] MW = AW'(MAX_WIDTH);

  logic [8:0] fw_r;
  logic [7:0] fh_r, rad_r;
  logic [4:0] minm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_WIDTH_RST; fh_r <= FRAME_HEIGHT_RST;
      rad_r <= MATCH_RADIUS_RST; minm_r <= MIN_MATCHES_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  fw_r   <= cfg_data[8:0];
        REG_FRAME_HEIGHT: fh_r   <= cfg_data[7:0];
        REG_MATCH_RADIUS: rad_r  <= cfg_data[7:0];
        REG_MIN_MATCHES:  minm_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [8:0] aw;
  logic [7:0] ah;
  assign aw = fw_r < MAXW9 ? fw_r : MAXW9;
  assign ah = fh_r < MAXH8 ? fh_r : MAXH8;

  state_t st_r, st_nxt;
  logic cmd_r, su_r, nu_r;
  logic [7:0] row_r, px_r;
  logic [8:0] col_r;
  logic [4:0] ss_r, ns_r;
  logic [2:0] nd_r;
  logic fg_r, fg_nxt, bd_r, bd_nxt, ov_r, ov_nxt;
  logic [AW-1:0] naddr_r, naddr_nxt;

  logic accept;
  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command; row_r <= in_row; col_r <= in_col;
      px_r <= in_pixel_value; su_r <= in_self_update; ss_r <= in_self_slot;
      nu_r <= in_neighbor_update; nd_r <= in_neighbor_dir;
      ns_r <= in_neighbor_slot;
    end
  end

  logic [AW-1:0] paddr;
  assign paddr = AW'(row_r) * MW + AW'(col_r);

  logic we;
  logic [AW-1:0] addr;
  logic [WW-1:0] wdata, rdata;

  vbs_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [CW-1:0] cnt;
  logic [7:0] d;
  always_comb begin
    cnt = '0;
    d = '0;
    for (int k = 0; k < NUM_SAMPLES; k++) begin
      d = rdata[8*k +: 8] > px_r ? rdata[8*k +: 8] - px_r : px_r - rdata[8*k +: 8];
      if (d <= rad_r) cnt = cnt + CW'(1);
    end
  end

  logic inside_frame, border;
  assign inside_frame = (row_r < ah) && (col_r < aw);
  assign border = (row_r == 8'd0) || (col_r == 9'd0) ||
                  ({1'b0, row_r} + 9'd1 >= {1'b0, ah}) ||
                  ({1'b0, col_r} + 10'd1 >= {1'b0, aw});

  logic [7:0] nr;
  logic [8:0] nc;
  always_comb begin
    nr = row_r;
    nc = col_r;
    unique case (dir_t'(nd_r))
      DIR_UL: begin nr = row_r - 8'd1; nc = col_r - 9'd1; end
      DIR_U:  nr = row_r - 8'd1;
      DIR_UR: begin nr = row_r - 8'd1; nc = col_r + 9'd1; end
      DIR_DL: begin nr = row_r + 8'd1; nc = col_r - 9'd1; end
      DIR_D:  nr = row_r + 8'd1;
      DIR_DR: begin nr = row_r + 8'd1; nc = col_r + 9'd1; end
      DIR_L:  nc = col_r - 9'd1;
      DIR_R:  nc = col_r + 9'd1;
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    fg_nxt = fg_r; bd_nxt = bd_r; ov_nxt = ov_r;
    naddr_nxt = naddr_r;
    we = 1'b0;
    addr = paddr;
    wdata = rdata;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_READ;
      ST_READ: begin
        fg_nxt = 1'b0; bd_nxt = 1'b0;
        if (cmd_r == CMD_INIT) begin
          we = inside_frame;
          wdata = {NUM_SAMPLES{px_r}};
          st_nxt = ST_OUT;
        end else if (border) begin
          bd_nxt = 1'b1;
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_EVAL;
        end
        naddr_nxt = AW'(nr) * MW + AW'(nc);
      end
      ST_EVAL: begin
        if ({{(8-CW){1'b0}}, cnt} < {3'd0, minm_r}) begin
          fg_nxt = 1'b1;
          st_nxt = ST_OUT;
        end else begin
          for (int k = 0; k < NUM_SAMPLES; k++)
            if (su_r && int'(ss_r) == k) wdata[8*k +: 8] = px_r;
          we = su_r;
          if (nu_r && {27'd0, ns_r} < NUM_SAMPLES) begin
            st_nxt = ST_NBR;
          end else begin
            st_nxt = ST_OUT;
          end
        end
      end
      ST_NBR: begin
        addr = naddr_r;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (cmd_r == CMD_DETECT && !bd_r && !fg_r && nu_r &&
            {27'd0, ns_r} < NUM_SAMPLES) begin
          addr = naddr_r;
          we = 1'b1;
          for (int k = 0; k < NUM_SAMPLES; k++)
            if (int'(ns_r) == k) wdata[8*k +: 8] = px_r;
        end
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // ST_OUT with neighbor write may repeat while output busy; write is idempotent.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fg_r <= fg_nxt;
    bd_r <= bd_nxt;
    naddr_r <= naddr_nxt;
  end

  logic ofg_r, obd_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && (!ov_r || !out_stall)) begin
      ofg_r <= fg_r;
      obd_r <= bd_r;
    end
  end

  assign out_valid = ov_r;
  assign out_is_foreground = ofg_r;
  assign out_on_border = obd_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> in_stall) else $error("accept while busy");
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == ST_READ) else $error("accept did not start read");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_foreground))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_foreground && out_on_border))
    else $error("foreground on border");

endmodule
